/* rtl/chs_pkg.sv */
// shared types and constants of the chained hash set
`timescale 1ns / 1ps

package chs_pkg;

	localparam logic [2:0] KIND_INSERT  = 3'd0;
	localparam logic [2:0] KIND_REMOVE  = 3'd1;
	localparam logic [2:0] KIND_LOOKUP  = 3'd2;
	localparam logic [2:0] KIND_REPLACE = 3'd3;
	localparam logic [2:0] KIND_CLEAR   = 3'd4;

	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_DUP  = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_MISS = 3'd3;
	localparam logic [2:0] ST_NULL = 3'd4;

	localparam logic [31:0] MIX_C1 = 32'h7feb352d;
	localparam logic [31:0] MIX_C2 = 32'h846ca68b;
	localparam int MIX_SH_A = 16;
	localparam int MIX_SH_B = 15;

	typedef struct packed {
		logic [2:0]         kind;
		logic [63:0]        key;
		logic signed [15:0] tag;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [5:0]         bucket;
		logic [7:0]         slot;
		logic signed [15:0] entry_type;
		logic [8:0]         live_entries;
		logic               is_full;
	} res_t;

endpackage

/* rtl/chs_ram.sv */
// generic single-write, single-read synchronous ram with registered read
`timescale 1ns / 1ps

module chs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/chs_hash.sv */
// key mixer: xor-shift-multiply with a shared 32x32 multiplier pair, then bucket reduction
`timescale 1ns / 1ps

module chs_hash #(
	parameter int BUCKETS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [63:0]                key,
	output logic                       done,
	output logic [$clog2(BUCKETS)-1:0] bucket
);

	localparam int BW = $clog2(BUCKETS);
	localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
	// reciprocal ceil(2^(32+BW) / BUCKETS), exact quotient for any 32-bit dividend
	localparam logic [63:0] RECIP = ((64'd1 << (32 + BW)) + 64'(BUCKETS) - 64'd1)
		/ 64'(BUCKETS);

	typedef enum logic [2:0] {H_IDLE, H_MUL, H_SUM, H_MOD, H_RED} hstate_t;

	hstate_t      state_q;
	logic         phase_q;
	logic [63:0]  a_q;
	logic [63:0]  plo_q;
	logic [31:0]  phi_q;
	logic [31:0]  h_q;
	logic [64:0]  prod_q;
	logic         done_q;
	logic [BW-1:0] bkt_q;

	logic [31:0] mul_c;
	logic [63:0] m_lo;
	logic [31:0] m_hi;
	logic [63:0] x_sum;
	logic [63:0] x_fin;
	logic [64:0] prod_c;
	logic [31:0] quo_c;
	logic [31:0] rem_c;

	assign mul_c  = phase_q ? chs_pkg::MIX_C2 : chs_pkg::MIX_C1;
	assign m_lo   = a_q[31:0] * mul_c;
	assign m_hi   = a_q[63:32] * mul_c;
	assign x_sum  = plo_q + {phi_q, 32'd0};
	assign x_fin  = x_sum ^ (x_sum >> chs_pkg::MIX_SH_A);
	assign prod_c = {33'd0, h_q} * {32'd0, RECIP[32:0]};
	assign quo_c  = 32'(prod_q >> (32 + BW));
	assign rem_c  = h_q - quo_c * 32'(BUCKETS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				H_IDLE: begin
					if (start) begin
						a_q     <= key ^ (key >> chs_pkg::MIX_SH_A);
						phase_q <= 1'b0;
						state_q <= H_MUL;
					end
				end
				H_MUL: begin
					plo_q   <= m_lo;
					phi_q   <= m_hi;
					state_q <= H_SUM;
				end
				H_SUM: begin
					if (!phase_q) begin
						a_q     <= x_sum ^ (x_sum >> chs_pkg::MIX_SH_B);
						phase_q <= 1'b1;
						state_q <= H_MUL;
					end else if (POW2) begin
						bkt_q   <= x_fin[BW-1:0];
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end else begin
						h_q     <= x_fin[31:0];
						state_q <= H_MOD;
					end
				end
				H_MOD: begin
					// quotient by reciprocal multiplication
					prod_q  <= prod_c;
					state_q <= H_RED;
				end
				H_RED: begin
					bkt_q   <= rem_c[BW-1:0];
					done_q  <= 1'b1;
					state_q <= H_IDLE;
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign bucket = bkt_q;

endmodule

/* rtl/chs_ctl.sv */
// table sequencer: chain walk, link updates and clearing sweep over the pool memories
`timescale 1ns / 1ps

module chs_ctl #(
	parameter int BUCKETS = 64,
	parameter int SLOTS   = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  chs_pkg::req_t              req,
	input  logic [$clog2(BUCKETS)-1:0] bucket,
	output logic                       ready,
	output logic                       res_valid,
	input  logic                       res_ready,
	output chs_pkg::res_t              res
);

	localparam int BW   = $clog2(BUCKETS);
	localparam int SW   = $clog2(SLOTS + 1);
	localparam int SAW  = $clog2(SLOTS);
	localparam int MAXN = (SLOTS > BUCKETS) ? SLOTS : BUCKETS;
	localparam int CW   = $clog2(MAXN);
	localparam logic [SW-1:0] NIL = SW'(SLOTS);

	typedef enum logic [3:0] {
		C_CLR, C_IDLE, C_HEAD, C_WALK, C_NF, C_FOUND,
		C_INS_W1, C_INS_W2, C_REM_W2, C_FIN
	} cstate_t;

	cstate_t        state_q;
	logic [CW-1:0]  ctr_q;
	logic           clr_reply_q;
	chs_pkg::req_t  req_q;
	logic [BW-1:0]  b_q;
	logic [SW-1:0]  head_q;
	logic [SW-1:0]  cur_q;
	logic [SW-1:0]  tail_q;
	logic           first_q;
	logic [SW-1:0]  nx_q;
	logic [SW-1:0]  pv_q;
	logic [15:0]    typ_q;
	logic [SW-1:0]  free_q;
	logic [SW-1:0]  live_q;
	logic [2:0]     status_q;
	logic [5:0]     bucket_q;
	logic [7:0]     slot_q;
	logic [15:0]    etype_q;

	// memory ports
	logic           hd_we;
	logic [BW-1:0]  hd_waddr;
	logic [SW-1:0]  hd_wdata;
	logic [SW-1:0]  hd_rdata;
	logic           nx_we;
	logic [SAW-1:0] nx_waddr;
	logic [SW-1:0]  nx_wdata;
	logic [SW-1:0]  nx_rdata;
	logic           pv_we;
	logic [SAW-1:0] pv_waddr;
	logic [SW-1:0]  pv_wdata;
	logic [SW-1:0]  pv_rdata;
	logic           us_we;
	logic [SAW-1:0] us_waddr;
	logic           us_wdata;
	logic           us_rdata;
	logic           ky_we;
	logic [63:0]    ky_rdata;
	logic           ty_we;
	logic [15:0]    ty_rdata;
	logic [SAW-1:0] dt_waddr;
	logic [SAW-1:0] slot_raddr;
	logic [SW-1:0]  slot_rsel;

	function automatic logic [7:0] to_slot(input logic [SW-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		return t[7:0];
	endfunction

	function automatic logic [5:0] to_bkt(input logic [BW-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		return t[5:0];
	endfunction

	function automatic logic [8:0] to_live(input logic [SW-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		return t[8:0];
	endfunction

	chs_ram #(.WIDTH(SW), .DEPTH(BUCKETS)) u_head (
		.clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
		.raddr(bucket), .rdata(hd_rdata)
	);
	chs_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
		.raddr(slot_raddr), .rdata(nx_rdata)
	);
	chs_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
		.raddr(slot_raddr), .rdata(pv_rdata)
	);
	chs_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_used (
		.clk(clk), .we(us_we), .waddr(us_waddr), .wdata(us_wdata),
		.raddr(slot_raddr), .rdata(us_rdata)
	);
	chs_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_key (
		.clk(clk), .we(ky_we), .waddr(dt_waddr), .wdata(req_q.key),
		.raddr(slot_raddr), .rdata(ky_rdata)
	);
	chs_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_type (
		.clk(clk), .we(ty_we), .waddr(dt_waddr), .wdata(req_q.tag),
		.raddr(slot_raddr), .rdata(ty_rdata)
	);

	// slot read address follows the walk, presented in the cycle before its compare
	always_comb begin
		case (state_q)
			C_HEAD:  slot_rsel = hd_rdata;
			C_WALK:  slot_rsel = nx_rdata;
			C_NF:    slot_rsel = free_q;
			default: slot_rsel = cur_q;
		endcase
	end
	assign slot_raddr = slot_rsel[SAW-1:0];

	always_comb begin
		hd_we    = 1'b0;
		hd_waddr = b_q;
		hd_wdata = NIL;
		nx_we    = 1'b0;
		nx_waddr = cur_q[SAW-1:0];
		nx_wdata = NIL;
		pv_we    = 1'b0;
		pv_waddr = cur_q[SAW-1:0];
		pv_wdata = NIL;
		us_we    = 1'b0;
		us_waddr = cur_q[SAW-1:0];
		us_wdata = 1'b0;
		ky_we    = 1'b0;
		ty_we    = 1'b0;
		dt_waddr = cur_q[SAW-1:0];
		case (state_q)
			C_CLR: begin
				if (32'(ctr_q) < SLOTS) begin
					nx_we    = 1'b1;
					nx_waddr = ctr_q[SAW-1:0];
					nx_wdata = SW'(32'(ctr_q) + 1);
					pv_we    = 1'b1;
					pv_waddr = ctr_q[SAW-1:0];
					us_we    = 1'b1;
					us_waddr = ctr_q[SAW-1:0];
				end
				if (32'(ctr_q) < BUCKETS) begin
					hd_we    = 1'b1;
					hd_waddr = ctr_q[BW-1:0];
				end
			end
			C_INS_W1: begin
				// new entry goes in front of the chain
				nx_we    = 1'b1;
				nx_waddr = free_q[SAW-1:0];
				nx_wdata = (head_q == NIL) ? free_q : head_q;
				pv_we    = 1'b1;
				pv_waddr = free_q[SAW-1:0];
				pv_wdata = (head_q == NIL) ? free_q : tail_q;
				us_we    = 1'b1;
				us_waddr = free_q[SAW-1:0];
				us_wdata = 1'b1;
				ky_we    = 1'b1;
				ty_we    = 1'b1;
				dt_waddr = free_q[SAW-1:0];
				hd_we    = 1'b1;
				hd_wdata = free_q;
			end
			C_INS_W2: begin
				pv_we    = 1'b1;
				pv_waddr = head_q[SAW-1:0];
				pv_wdata = cur_q;
				nx_we    = 1'b1;
				nx_waddr = tail_q[SAW-1:0];
				nx_wdata = cur_q;
			end
			C_FOUND: begin
				if (req_q.kind == chs_pkg::KIND_REPLACE) begin
					ty_we = 1'b1;
				end else if (req_q.kind == chs_pkg::KIND_REMOVE) begin
					us_we = 1'b1;
					if (nx_q == cur_q) begin
						hd_we = 1'b1;
					end else begin
						nx_we    = 1'b1;
						nx_waddr = pv_q[SAW-1:0];
						nx_wdata = nx_q;
						pv_we    = 1'b1;
						pv_waddr = nx_q[SAW-1:0];
						pv_wdata = pv_q;
						hd_we    = (head_q == cur_q);
						hd_wdata = nx_q;
					end
				end
			end
			C_REM_W2: begin
				nx_we    = 1'b1;
				nx_wdata = free_q;
				pv_we    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_CLR;
			ctr_q       <= '0;
			clr_reply_q <= 1'b0;
			free_q      <= '0;
			live_q      <= '0;
		end else begin
			case (state_q)
				C_CLR: begin
					ctr_q <= ctr_q + CW'(1);
					if (ctr_q == CW'(MAXN - 1)) begin
						free_q  <= '0;
						live_q  <= '0;
						state_q <= clr_reply_q ? C_FIN : C_IDLE;
					end
				end
				C_IDLE: begin
					if (start) begin
						req_q    <= req;
						b_q      <= bucket;
						status_q <= chs_pkg::ST_OK;
						bucket_q <= to_bkt(bucket);
						slot_q   <= '0;
						etype_q  <= '0;
						if (req.kind == chs_pkg::KIND_CLEAR) begin
							bucket_q    <= '0;
							ctr_q       <= '0;
							clr_reply_q <= 1'b1;
							state_q     <= C_CLR;
						end else if (req.kind > chs_pkg::KIND_CLEAR) begin
							state_q <= C_FIN;
						end else if (req.key == 64'd0) begin
							status_q <= chs_pkg::ST_NULL;
							state_q  <= C_FIN;
						end else if (req.kind == chs_pkg::KIND_INSERT && free_q == NIL) begin
							status_q <= chs_pkg::ST_FULL;
							state_q  <= C_FIN;
						end else begin
							state_q <= C_HEAD;
						end
					end
				end
				C_HEAD: begin
					head_q  <= hd_rdata;
					cur_q   <= hd_rdata;
					first_q <= 1'b1;
					state_q <= (hd_rdata == NIL) ? C_NF : C_WALK;
				end
				C_WALK: begin
					first_q <= 1'b0;
					if (first_q) begin
						tail_q <= pv_rdata;
					end
					if (us_rdata && ky_rdata == req_q.key) begin
						nx_q    <= nx_rdata;
						pv_q    <= pv_rdata;
						typ_q   <= ty_rdata;
						state_q <= C_FOUND;
					end else if (nx_rdata >= NIL || nx_rdata == head_q) begin
						state_q <= C_NF;
					end else begin
						cur_q <= nx_rdata;
					end
				end
				C_NF: begin
					if (req_q.kind == chs_pkg::KIND_INSERT) begin
						state_q <= C_INS_W1;
					end else begin
						status_q <= chs_pkg::ST_MISS;
						state_q  <= C_FIN;
					end
				end
				C_INS_W1: begin
					// read data holds the free successor of the new slot
					free_q  <= nx_rdata;
					cur_q   <= free_q;
					live_q  <= live_q + SW'(1);
					slot_q  <= to_slot(free_q);
					state_q <= (head_q == NIL) ? C_FIN : C_INS_W2;
				end
				C_INS_W2: begin
					state_q <= C_FIN;
				end
				C_FOUND: begin
					slot_q  <= to_slot(cur_q);
					state_q <= C_FIN;
					case (req_q.kind)
						chs_pkg::KIND_INSERT:  status_q <= chs_pkg::ST_DUP;
						chs_pkg::KIND_LOOKUP:  etype_q  <= typ_q;
						chs_pkg::KIND_REPLACE: etype_q  <= req_q.tag;
						chs_pkg::KIND_REMOVE:  state_q  <= C_REM_W2;
						default:               status_q <= chs_pkg::ST_OK;
					endcase
				end
				C_REM_W2: begin
					free_q <= cur_q;
					if (live_q != '0) begin
						live_q <= live_q - SW'(1);
					end
					state_q <= C_FIN;
				end
				C_FIN: begin
					clr_reply_q <= 1'b0;
					if (res_ready) begin
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign ready     = (state_q == C_IDLE);
	assign res_valid = (state_q == C_FIN);

	always_comb begin
		res.status       = status_q;
		res.bucket       = bucket_q;
		res.slot         = slot_q;
		res.entry_type   = etype_q;
		res.live_entries = to_live(live_q);
		res.is_full      = (free_q == NIL);
	end

endmodule

/* rtl/chained_hash_set_with_slot_pool_top.sv */
// top level of the chained hash set: stream ports, key mixer, sequencer, result register
//
// channel | dir | tdata (low bit up)                                   | tuser
// s_      | in  | key[63:0], type_tag[79:64]                           | kind[2:0]
// m_      | out | bucket[5:0], slot[13:6], entry_type[29:14],          | status[2:0]
//         |     | live_entries[38:30], is_full[39]                     |
//
// one item at a time: two multiply rounds of key mixing (plus the H_MOD and H_RED states when
// BUCKETS is not a power of two), then the sequencer reads the bucket head, walks the chain
// one entry per cycle through the slot memories and writes the links. clear sweeps every slot
// and bucket in the sequencer; after reset the same sweep runs before s_tready rises.
// a result waits in the output register; the next transaction is taken meanwhile.
`timescale 1ns / 1ps

module chained_hash_set_with_slot_pool_top #(
	parameter int BUCKETS = 64,
	parameter int SLOTS   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // key, type_tag
	input  logic [2:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // bucket, slot, entry_type, live_entries, is_full
	output logic [2:0]  m_tuser    // status
);

	localparam int BW = $clog2(BUCKETS);

	chs_pkg::req_t req_q;
	chs_pkg::res_t res;
	logic          busy_q;
	logic          m_valid_q;
	logic [39:0]   m_data_q;
	logic [2:0]    m_user_q;
	logic          accept;
	logic          hash_done;
	logic [BW-1:0] hash_bkt;
	logic          ctl_ready;
	logic          res_valid;
	logic          res_ready;

	assign s_tready  = !busy_q && ctl_ready;
	assign accept    = s_tvalid && s_tready;
	assign res_ready = !m_valid_q || m_tready;

	chs_hash #(.BUCKETS(BUCKETS)) u_hash (
		.clk(clk), .arst_n(arst_n), .start(accept), .key(s_tdata[63:0]),
		.done(hash_done), .bucket(hash_bkt)
	);

	chs_ctl #(.BUCKETS(BUCKETS), .SLOTS(SLOTS)) u_ctl (
		.clk(clk), .arst_n(arst_n), .start(hash_done), .req(req_q), .bucket(hash_bkt),
		.ready(ctl_ready), .res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.kind <= s_tuser;
			req_q.key  <= s_tdata[63:0];
			req_q.tag  <= s_tdata[79:64];
		end
		if (res_valid && res_ready) begin
			m_data_q <= {res.is_full, res.live_entries, res.entry_type, res.slot, res.bucket};
			m_user_q <= res.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (res_valid && res_ready) begin
				busy_q <= 1'b0;
			end
			if (res_valid && res_ready) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

/* test/chs_checker.sv */
// checker for the chained hash set: tracks transactions, predicts results and compares them
`timescale 1ns / 1ps

module chs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [79:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic [2:0]  m_tuser,
	output int          errors,
	output int          pending
);

	localparam int NBUCK = 64;
	localparam int NSLOT = 256;
	localparam int NIL   = NSLOT;

	int unsigned         chain_head [NBUCK];
	logic [63:0]         pool_key   [NSLOT];
	logic signed [15:0]  pool_tag   [NSLOT];
	int unsigned         pool_next  [NSLOT];
	int unsigned         pool_prev  [NSLOT];
	bit                  pool_used  [NSLOT];
	int unsigned         free_top;
	int unsigned         occupied;

	chs_pkg::res_t expected_results [$];

	task automatic clear_model();
		for (int i = 0; i < NBUCK; i++) chain_head[i] = NIL;
		for (int i = 0; i < NSLOT; i++) begin
			pool_key[i]  = '0;
			pool_tag[i]  = '0;
			pool_next[i] = i + 1;
			pool_prev[i] = NIL;
			pool_used[i] = 0;
		end
		free_top = 0;
		occupied = 0;
	endtask

	function automatic int unsigned key_bucket(logic [63:0] k);
		logic [63:0] x;
		x = k;
		x = x ^ (x >> chs_pkg::MIX_SH_A);
		x = x * {32'h0, chs_pkg::MIX_C1};
		x = x ^ (x >> chs_pkg::MIX_SH_B);
		x = x * {32'h0, chs_pkg::MIX_C2};
		x = x ^ (x >> chs_pkg::MIX_SH_A);
		return int'(x[31:0] % NBUCK);
	endfunction

	function automatic int unsigned chain_find(int unsigned b, logic [63:0] k);
		int unsigned hd;
		int unsigned cur;
		hd = chain_head[b];
		if (hd >= NIL) return NIL;
		cur = hd;
		for (int n = 0; n < NSLOT; n++) begin
			if (pool_used[cur] && pool_key[cur] == k) return cur;
			cur = pool_next[cur];
			if (cur >= NIL || cur == hd) break;
		end
		return NIL;
	endfunction

	task automatic apply_op(input logic [2:0] kind, input logic [63:0] k,
			input logic signed [15:0] tag, output chs_pkg::res_t r);
		int unsigned b;
		int unsigned f;
		int unsigned hd;
		int unsigned tl;
		int unsigned nx;
		int unsigned pv;
		r = '0;
		if (kind == chs_pkg::KIND_CLEAR) begin
			clear_model();
		end else begin
			b = key_bucket(k);
			r.bucket = b[5:0];
			if (kind <= chs_pkg::KIND_REPLACE && k == 64'd0) begin
				r.status = chs_pkg::ST_NULL;
			end else if (kind == chs_pkg::KIND_INSERT) begin
				if (free_top >= NIL) begin
					r.status = chs_pkg::ST_FULL;
				end else begin
					f = chain_find(b, k);
					if (f != NIL) begin
						r.status = chs_pkg::ST_DUP;
						r.slot = f[7:0];
					end else begin
						f = free_top;
						hd = chain_head[b];
						free_top = pool_next[f];
						pool_key[f] = k;
						pool_tag[f] = tag;
						pool_used[f] = 1;
						occupied++;
						if (hd >= NIL) begin
							pool_next[f] = f;
							pool_prev[f] = f;
						end else begin
							tl = pool_prev[hd];
							pool_next[f] = hd;
							pool_prev[f] = tl;
							pool_prev[hd] = f;
							if (tl < NIL) pool_next[tl] = f;
						end
						chain_head[b] = f;
						r.slot = f[7:0];
					end
				end
			end else if (kind <= chs_pkg::KIND_REPLACE) begin
				f = chain_find(b, k);
				if (f == NIL) begin
					r.status = chs_pkg::ST_MISS;
				end else if (kind == chs_pkg::KIND_REMOVE) begin
					nx = pool_next[f];
					pv = pool_prev[f];
					if (nx == f) begin
						chain_head[b] = NIL;
					end else begin
						if (pv < NIL) pool_next[pv] = nx;
						if (nx < NIL) pool_prev[nx] = pv;
						if (chain_head[b] == f) chain_head[b] = nx;
					end
					pool_used[f] = 0;
					pool_key[f] = '0;
					pool_tag[f] = '0;
					pool_prev[f] = NIL;
					pool_next[f] = free_top;
					free_top = f;
					if (occupied > 0) occupied--;
					r.slot = f[7:0];
				end else if (kind == chs_pkg::KIND_LOOKUP) begin
					r.slot = f[7:0];
					r.entry_type = pool_tag[f];
				end else begin
					pool_tag[f] = tag;
					r.slot = f[7:0];
					r.entry_type = tag;
				end
			end
		end
		r.live_entries = occupied[8:0];
		r.is_full = (free_top >= NIL);
	endtask

	task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		chs_pkg::res_t want;
		chs_pkg::res_t got;
		if (!arst_n) begin
			clear_model();
			expected_results.delete();
			pending <= 0;
			errors = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status       = m_tuser;
				got.bucket       = m_tdata[5:0];
				got.slot         = m_tdata[13:6];
				got.entry_type   = m_tdata[29:14];
				got.live_entries = m_tdata[38:30];
				got.is_full      = m_tdata[39];
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0h", $time, got);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", want.status, got.status);
					check_field("bucket", want.bucket, got.bucket);
					check_field("slot", want.slot, got.slot);
					check_field("entry_type", want.entry_type, got.entry_type);
					check_field("live_entries", want.live_entries, got.live_entries);
					check_field("is_full", want.is_full, got.is_full);
				end
			end
			if (s_tvalid && s_tready) begin
				apply_op(s_tuser, s_tdata[63:0], s_tdata[79:64], want);
				expected_results.push_back(want);
			end
			pending <= expected_results.size();
		end
	end

endmodule

/* test/tb_chained_hash_set_with_slot_pool_top.sv */
// stimulus and verdict for the chained hash set stream block
`timescale 1ns / 1ps

module tb_chained_hash_set_with_slot_pool_top;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [2:0]  m_tuser;
	int          errors;
	int          pending;

	int          idle_pct;
	int          stall_pct;
	bit          hold_req;
	int          hold_left;
	logic [63:0] key_pool [40];

	chained_hash_set_with_slot_pool_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	chs_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.errors(errors), .pending(pending)
	);

	always #6 clk = ~clk;

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send(input logic [2:0] kind, input logic [63:0] k,
			input logic signed [15:0] tag);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {tag, k};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_op();
		int r;
		logic [2:0] kind;
		logic [63:0] k;
		r = $urandom_range(99);
		if (r < 36) kind = chs_pkg::KIND_INSERT;
		else if (r < 56) kind = chs_pkg::KIND_REMOVE;
		else if (r < 76) kind = chs_pkg::KIND_LOOKUP;
		else if (r < 94) kind = chs_pkg::KIND_REPLACE;
		else if (r < 95) kind = chs_pkg::KIND_CLEAR;
		else kind = 3'($urandom_range(7, 5));
		r = $urandom_range(99);
		if (r < 88) k = key_pool[$urandom_range(39)];
		else if (r < 93) k = 64'd0;
		else k = {$urandom, $urandom};
		send(kind, k, 16'($urandom));
	endtask

	initial begin
		clk = 0;
		arst_n = 1;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		hold_left = 0;
		for (int i = 0; i < 40; i++) key_pool[i] = {$urandom, $urandom};
		@(posedge clk);
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every kind, null key, misses, duplicates
		send(chs_pkg::KIND_LOOKUP, 64'd5, 16'sd0);
		send(chs_pkg::KIND_INSERT, 64'd0, 16'sd1);
		send(chs_pkg::KIND_REMOVE, 64'd0, 16'sd0);
		send(chs_pkg::KIND_LOOKUP, 64'd0, 16'sd0);
		send(chs_pkg::KIND_REPLACE, 64'd0, 16'sd7);
		send(chs_pkg::KIND_INSERT, 64'hffff_ffff_ffff_ffff, -16'sd32768);
		send(chs_pkg::KIND_INSERT, 64'd1, 16'sd32767);
		send(chs_pkg::KIND_INSERT, 64'd1, 16'sd3);
		send(chs_pkg::KIND_LOOKUP, 64'hffff_ffff_ffff_ffff, 16'sd0);
		send(chs_pkg::KIND_REPLACE, 64'd1, -16'sd1);
		send(chs_pkg::KIND_LOOKUP, 64'd1, 16'sd0);
		send(chs_pkg::KIND_REMOVE, 64'd2, 16'sd0);
		send(chs_pkg::KIND_REMOVE, 64'd1, 16'sd0);
		send(chs_pkg::KIND_LOOKUP, 64'd1, 16'sd0);
		send(chs_pkg::KIND_REPLACE, 64'd1, 16'sd9);
		send(3'd5, 64'd0, 16'sd0);
		send(3'd6, 64'h8000_0000_0000_0000, 16'sd0);
		send(3'd7, 64'hffff_ffff_ffff_ffff, -16'sd1);
		send(chs_pkg::KIND_CLEAR, 64'hffff_ffff_ffff_ffff, -16'sd1);
		send(chs_pkg::KIND_LOOKUP, 64'hffff_ffff_ffff_ffff, 16'sd0);

		// fill the pool past full, opening with a receiver hold-off that stalls the inserts
		hold_req = 1;
		for (int i = 0; i < 258; i++) begin
			send(chs_pkg::KIND_INSERT, {$urandom, $urandom} | 64'd1, 16'($urandom));
		end
		send(chs_pkg::KIND_INSERT, 64'hffff_ffff_ffff_ffff, 16'sd0);
		for (int i = 0; i < 30; i++) random_op();
		drain();
		send(chs_pkg::KIND_CLEAR, 64'd0, 16'sd0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 84; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 84; end
				default: begin idle_pct = 17; stall_pct = 17; end
			endcase
			for (int i = 0; i < 400; i++) begin
				random_op();
				if (ph == 1 && i == 200) drain();
			end
		end

		drain();
		repeat (400) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("tb_chained_hash_set_with_slot_pool_top: clean");
		end else begin
			$display("tb_chained_hash_set_with_slot_pool_top: errors");
		end
		$finish;
	end

	initial begin
		#60_000_000;
		$display("tb_chained_hash_set_with_slot_pool_top: errors");
		$finish;
	end

endmodule
